### design/color_lut_3d_interpolate_macros.svh
// Assertion macros for the 3D color table grading block.
// Depends on nothing; included by the files that check their own logic.
`ifndef COLOR_LUT_3D_INTERPOLATE_MACROS_SVH
`define COLOR_LUT_3D_INTERPOLATE_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every edge outside reset
`define CL3D_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("cl3d assertion failed");

// expression must never be true outside reset
`define CL3D_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("cl3d forbidden condition");

`else

`define CL3D_ASSERT(lbl, clk, rst, prop)
`define CL3D_NEVER(lbl, clk, rst, expr)

`endif

`endif

### design/cl3d_pkg.sv
// Shared types and fixed field widths for the 3D color table grading block.
// No dependencies.
package cl3d_pkg;

   // one byte-aligned word on each side
   localparam int ENTRY_W    = 13;
   localparam int PIX_W      = 8;
   localparam int INDEX_W    = 15;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 24;
   localparam int CHANNELS   = 3;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_PIXEL = 1'b1
   } cmd_type;

endpackage

### design/cl3d_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module cl3d_ram #(
   parameter int WIDTH = 39,
   parameter int DEPTH = 32768,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/color_lut_3d_interpolate.sv
// A pixel word passes through s1 to s5 and the output register before it leaves on rsp_.
// Throughput: one word per clock; the six-stage pipeline stalls as a whole only
// while the output register holds a word that is not taken.
// Load words write both table copies in the accepting cycle and give no result.
// Reset clears the table-ready flag and all valid bits; table contents are
// undefined until written, and pixels yield nothing until the last entry lands.
`include "color_lut_3d_interpolate_macros.svh"

module color_lut_3d_interpolate
   import cl3d_pkg::*;
#(
   parameter int GRID_POINTS     = 32,
   parameter int ENTRY_FRAC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index[14:0], entry_red[27:15], entry_green[40:28], entry_blue[53:41],
   // pixel_red[61:54], pixel_green[69:62], pixel_blue[77:70], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_red[7:0], out_green[15:8], out_blue[23:16]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int Cell      = 256 / GRID_POINTS;
   localparam int TableSize = GRID_POINTS * GRID_POINTS * GRID_POINTS;
   localparam int AW        = $clog2(TableSize);
   localparam int IW        = $clog2(GRID_POINTS);
   localparam int FW        = $clog2(Cell);
   localparam int CW        = $clog2(Cell + 1);
   localparam int NW        = ENTRY_W + CW;
   localparam int PW        = NW + 8;
   localparam int XW        = PW - ENTRY_FRAC_BITS;
   localparam int SW        = $clog2(256 * Cell);
   localparam int MW        = (XW > SW) ? XW : SW;
   localparam int WORD_W    = CHANNELS * ENTRY_W;
   // ceil(2^16 / Cell): exact quotient for 8-bit values
   localparam logic [16:0] IdxRecip = 17'(((1 << 16) + Cell - 1) / Cell);
   // floor(2^SW / Cell): quotient low by at most one, fixed up afterwards
   localparam logic [SW-1:0] DivRecip = SW'((1 << SW) / Cell);
   localparam logic [MW-1:0] SatLimit = MW'(256 * Cell);
   localparam logic [7:0]  TopIdx     = 8'(GRID_POINTS - 1);
   localparam logic [IW-1:0] ClampIdx = IW'(GRID_POINTS - 2);
   localparam logic [AW-1:0] RowStep  = AW'(GRID_POINTS);
   localparam logic [AW-1:0] PlaneStep = AW'(GRID_POINTS * GRID_POINTS);
   localparam logic [AW-1:0] DiagStep = AW'(1 + GRID_POINTS + GRID_POINTS * GRID_POINTS);
   localparam logic [CW-1:0] CellW    = CW'(Cell);
   localparam logic [SW-1:0] CellS    = SW'(Cell);

   // ---------------- handshake and load path
   logic     advance;
   logic     req_fire;
   cmd_type  req_cmd;
   logic [INDEX_W-1:0] req_index;
   logic     index_ok;
   logic     wr_en;
   logic [WORD_W-1:0] wr_word;
   logic [AW-1:0]     wr_addr;
   logic     table_ready_ff, table_ready_in;

   logic     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign req_fire   = req_tvalid && advance;
   assign req_cmd    = cmd_type'(req_tuser);
   assign req_index  = req_tdata[14:0];
   assign index_ok   = 32'(req_index) < TableSize;
   assign wr_en      = req_fire && (req_cmd == CMD_LOAD) && index_ok;
   assign wr_addr    = AW'(req_index);
   assign wr_word    = req_tdata[53:15];

   assign table_ready_in = table_ready_ff
                           || (wr_en && (32'(req_index) == TableSize - 1));

   // ---------------- pipeline registers
   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_pix_ff [CHANNELS];
   logic [7:0]        s1_raw_ff [CHANNELS];
   logic [7:0]        s1_raw_in [CHANNELS];

   logic              s2_valid_ff;
   logic [FW-1:0]     s2_frac_ff [CHANNELS];
   logic [FW-1:0]     s2_frac_in [CHANNELS];

   logic              s3_valid_ff;
   logic [NW-1:0]     s3_sum_ff [CHANNELS];
   logic [NW-1:0]     s3_sum_in [CHANNELS];

   logic              s4_valid_ff;
   logic [SW-1:0]     s4_x_ff [CHANNELS];
   logic [SW-1:0]     s4_x_in [CHANNELS];
   logic [CHANNELS-1:0] s4_sat_ff, s4_sat_in;

   logic              s5_valid_ff;
   logic [SW-1:0]     s5_x_ff [CHANNELS];
   logic [7:0]        s5_q_ff [CHANNELS];
   logic [7:0]        s5_q_in [CHANNELS];
   logic [CHANNELS-1:0] s5_sat_ff;

   logic [7:0]        pix_in [CHANNELS];
   logic [IW-1:0]     grid_idx [CHANNELS];
   logic [AW-1:0]     rd_addr_lo, rd_addr_hi;
   logic [WORD_W-1:0] rd_word_lo, rd_word_hi;

   assign pix_in[0] = req_tdata[61:54];
   assign pix_in[1] = req_tdata[69:62];
   assign pix_in[2] = req_tdata[77:70];
   assign s1_valid_in = req_fire && (req_cmd == CMD_PIXEL) && table_ready_ff;

   // stage 0: grid index by reciprocal multiply
   always_comb begin
      logic [24:0] prod;
      for (int k = 0; k < CHANNELS; k++) begin
         prod = 25'(pix_in[k]) * 25'(IdxRecip);
         s1_raw_in[k] = prod[23:16];
      end
   end

   // stage 1: clamp, cell fraction, the two table addresses
   always_comb begin
      logic [15:0] base;
      for (int k = 0; k < CHANNELS; k++) begin
         grid_idx[k] = (s1_raw_ff[k] >= TopIdx) ? ClampIdx : IW'(s1_raw_ff[k]);
         base = 16'(s1_raw_ff[k]) * 16'(Cell);
         s2_frac_in[k] = FW'(16'(s1_pix_ff[k]) - base);
      end
      rd_addr_lo = AW'(grid_idx[0]) + AW'(grid_idx[1]) * RowStep
                   + AW'(grid_idx[2]) * PlaneStep;
      // top cell is never chosen, so this stays inside the table
      rd_addr_hi = rd_addr_lo + DiagStep;
   end

   cl3d_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TableSize)
   ) u_ram_lo (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (advance),
      .rd_addr (rd_addr_lo),
      .rd_data (rd_word_lo)
   );

   cl3d_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TableSize)
   ) u_ram_hi (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (advance),
      .rd_addr (rd_addr_hi),
      .rd_data (rd_word_hi)
   );

   // stage 2: weighted sum, units of 1/(Cell << frac bits)
   always_comb begin
      logic [ENTRY_W-1:0] lo_val, hi_val;
      logic [CW-1:0]      w_hi, w_lo;
      for (int k = 0; k < CHANNELS; k++) begin
         lo_val = rd_word_lo[k*ENTRY_W +: ENTRY_W];
         hi_val = rd_word_hi[k*ENTRY_W +: ENTRY_W];
         w_hi = CW'(s2_frac_ff[k]);
         w_lo = CellW - w_hi;
         s3_sum_in[k] = NW'(NW'(lo_val) * NW'(w_lo)) + NW'(NW'(hi_val) * NW'(w_hi));
      end
   end

   // stage 3: times 255, drop frac bits, saturate check
   always_comb begin
      logic [PW-1:0] scaled;
      logic [XW-1:0] shifted;
      logic [MW-1:0] wide;
      for (int k = 0; k < CHANNELS; k++) begin
         scaled = (PW'(s3_sum_ff[k]) << 8) - PW'(s3_sum_ff[k]);
         shifted = scaled[PW-1:ENTRY_FRAC_BITS];
         wide = MW'(shifted);
         s4_sat_in[k] = wide >= SatLimit;
         s4_x_in[k] = SW'(wide);
      end
   end

   // stage 4: estimated quotient by Cell
   always_comb begin
      logic [2*SW-1:0] prod;
      for (int k = 0; k < CHANNELS; k++) begin
         prod = (2*SW)'(s4_x_ff[k]) * (2*SW)'(DivRecip);
         s5_q_in[k] = prod[SW +: 8];
      end
   end

   // stage 5: quotient fix-up and output clamp
   always_comb begin
      logic [SW-1:0] rem;
      logic [7:0]    q;
      rsp_data_in = '0;
      for (int k = 0; k < CHANNELS; k++) begin
         rem = s5_x_ff[k] - SW'(s5_q_ff[k]) * CellS;
         q = (rem >= CellS) ? s5_q_ff[k] + 8'd1 : s5_q_ff[k];
         rsp_data_in[k*8 +: 8] = s5_sat_ff[k] ? 8'hFF : q;
      end
   end

   assign rsp_valid_in = advance ? s5_valid_ff : rsp_valid_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         table_ready_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s4_valid_ff    <= 1'b0;
         s5_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         table_ready_ff <= table_ready_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance) begin
            s1_valid_ff <= s1_valid_in;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < CHANNELS; k++) begin
            s1_pix_ff[k]  <= pix_in[k];
            s1_raw_ff[k]  <= s1_raw_in[k];
            s2_frac_ff[k] <= s2_frac_in[k];
            s3_sum_ff[k]  <= s3_sum_in[k];
            s4_x_ff[k]    <= s4_x_in[k];
            s5_x_ff[k]    <= s4_x_ff[k];
            s5_q_ff[k]    <= s5_q_in[k];
         end
         s4_sat_ff   <= s4_sat_in;
         s5_sat_ff   <= s4_sat_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- checks
   `CL3D_ASSERT(a_ready_sticky, clock, reset, table_ready_ff |=> table_ready_ff)
   `CL3D_ASSERT(a_load_no_result, clock, reset, (req_fire && req_cmd == CMD_LOAD) |=> !s1_valid_ff)
   `CL3D_ASSERT(a_early_pixel_dropped, clock, reset, (req_fire && !table_ready_ff) |=> !s1_valid_ff)
   `CL3D_ASSERT(a_stall_holds_pipe, clock, reset, !advance |=> $stable({s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff}))

endmodule
